[rtl/core/ymf_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ymf_pkg
// Shared types, line constants and the CRC-16/XMODEM byte step for the
// YMODEM packet framer.
// ----------------------------------------------------------------------------
package ymf_pkg;

    localparam int FS_W    = 22;
    localparam int BYTE_W  = 8;
    localparam int LANES_W = 64;
    localparam int LCNT_W  = 3;
    localparam int CNT_W   = 4;
    localparam int CRC_W   = 16;

    localparam logic [BYTE_W-1:0] HDR_SMALL = 8'h01;
    localparam logic [BYTE_W-1:0] HDR_LARGE = 8'h02;
    localparam logic [BYTE_W-1:0] PAD_BYTE  = 8'h1A;
    localparam logic [CRC_W-1:0]  CRC_POLY  = 16'h1021;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BLK,
        ST_NBLK,
        ST_DATA,
        ST_PAD,
        ST_CRCH,
        ST_CRCL
    } t_state;

    typedef enum logic [2:0] {
        SEL_HDR,
        SEL_BLK,
        SEL_NBLK,
        SEL_DIN,
        SEL_DREG,
        SEL_PAD,
        SEL_CRCH,
        SEL_CRCL
    } t_byte_sel;

    // controller -> datapath
    typedef struct packed {
        logic      push;   // one line byte into the packer
        logic      last;   // last line byte of this input
        logic      start;  // open a packet, latch the input byte
        logic      data;   // file byte: crc, position, remaining
        logic      pad;    // padding byte: crc, position
        logic      close;  // CRC low byte: close the packet
        t_byte_sel sel;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic in_packet;
        logic last_data;  // one file byte left
        logic pos_last;   // next payload byte fills the packet
        logic can_push;
    } t_status;

    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[CRC_W-1]) begin
                c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[CRC_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage
`default_nettype wire

[rtl/core/ymodem_packet_framer.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ymodem_packet_framer
// Frames a byte stream into YMODEM data packets with CRC-16/XMODEM,
// up to eight line bytes to a result beat.
// ----------------------------------------------------------------------------
// Line bytes leave the framer one per cycle through an eight-lane packer
// while the output register has room. An input byte causes one line byte
// inside a packet, four for the byte that opens a packet
// (header, block number, inverse, data), two more for the byte that closes
// a packet (CRC high and low), and one more per padding byte after the
// last file byte (up to SMALL_PAYLOAD - 1). A new byte is taken only once
// the previous one's line bytes are all in the packer; a result waiting in
// the output register stalls the packer. file_size is picked up when the
// next file's first packet opens.
// ----------------------------------------------------------------------------
module ymodem_packet_framer #(
    parameter int LARGE_PAYLOAD = 1024,
    parameter int SMALL_PAYLOAD = 128
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [ymf_pkg::FS_W-1:0]       i_cfg_file_size,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic [ymf_pkg::BYTE_W-1:0]     i_data_byte,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic [ymf_pkg::LANES_W-1:0]         o_byte_lanes,
    output logic [ymf_pkg::CNT_W-1:0]           o_byte_count,
    output logic                                o_packet_end,
    output logic                                o_file_end,
    output logic                                o_run_last
);

    ymf_pkg::t_cmd    cmd;
    ymf_pkg::t_status st;

    assign o_cfg_ready = 1'b1;

    ymf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_st       (st),
        .o_cmd      (cmd)
    );

    ymf_datapath #(
        .LARGE_PAYLOAD (LARGE_PAYLOAD),
        .SMALL_PAYLOAD (SMALL_PAYLOAD)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_valid && o_cfg_ready),
        .i_cfg_file_size (i_cfg_file_size),
        .i_data_byte     (i_data_byte),
        .i_cmd           (cmd),
        .o_st            (st),
        .i_out_ready     (i_out_ready),
        .o_out_valid     (o_out_valid),
        .o_byte_lanes    (o_byte_lanes),
        .o_byte_count    (o_byte_count),
        .o_packet_end    (o_packet_end),
        .o_file_end      (o_file_end),
        .o_run_last      (o_run_last)
    );

endmodule
`default_nettype wire

[rtl/core/ymf_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ymf_ctrl
// Sequencer of the framer: walks header, payload, padding and CRC bytes,
// one line byte per cycle while the result register has room, and issues commands to the datapath.
// ----------------------------------------------------------------------------
module ymf_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire ymf_pkg::t_status i_st,
    output ymf_pkg::t_cmd         o_cmd
);

    ymf_pkg::t_state r_state;
    ymf_pkg::t_state n_state;
    logic            accept;
    logic            data_end;

    assign o_in_ready = (r_state == ymf_pkg::ST_IDLE) && i_st.can_push;
    assign accept     = i_in_valid && o_in_ready;
    // a file byte that neither ends the file nor fills the packet ends the input
    assign data_end   = !i_st.last_data && !i_st.pos_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ymf_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    function automatic ymf_pkg::t_state after_data(input ymf_pkg::t_status st);
        if (st.pos_last) begin
            return ymf_pkg::ST_CRCH;
        end else if (st.last_data) begin
            return ymf_pkg::ST_PAD;
        end
        return ymf_pkg::ST_IDLE;
    endfunction

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ymf_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = i_st.in_packet ? after_data(i_st) : ymf_pkg::ST_BLK;
                end
            end
            ymf_pkg::ST_BLK:  if (i_st.can_push) n_state = ymf_pkg::ST_NBLK;
            ymf_pkg::ST_NBLK: if (i_st.can_push) n_state = ymf_pkg::ST_DATA;
            ymf_pkg::ST_DATA: if (i_st.can_push) n_state = after_data(i_st);
            ymf_pkg::ST_PAD: begin
                if (i_st.can_push && i_st.pos_last) n_state = ymf_pkg::ST_CRCH;
            end
            ymf_pkg::ST_CRCH: if (i_st.can_push) n_state = ymf_pkg::ST_CRCL;
            ymf_pkg::ST_CRCL: if (i_st.can_push) n_state = ymf_pkg::ST_IDLE;
            default:          n_state = ymf_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd     = '0;
        o_cmd.sel = ymf_pkg::SEL_HDR;
        unique case (r_state)
            ymf_pkg::ST_IDLE: begin
                if (accept) begin
                    o_cmd.push = 1'b1;
                    if (!i_st.in_packet) begin
                        o_cmd.start = 1'b1;
                        o_cmd.sel   = ymf_pkg::SEL_HDR;
                    end else begin
                        o_cmd.data = 1'b1;
                        o_cmd.last = data_end;
                        o_cmd.sel  = ymf_pkg::SEL_DIN;
                    end
                end
            end
            ymf_pkg::ST_BLK: begin
                o_cmd.push = i_st.can_push;
                o_cmd.sel  = ymf_pkg::SEL_BLK;
            end
            ymf_pkg::ST_NBLK: begin
                o_cmd.push = i_st.can_push;
                o_cmd.sel  = ymf_pkg::SEL_NBLK;
            end
            ymf_pkg::ST_DATA: begin
                o_cmd.push = i_st.can_push;
                o_cmd.data = i_st.can_push;
                o_cmd.last = i_st.can_push && data_end;
                o_cmd.sel  = ymf_pkg::SEL_DREG;
            end
            ymf_pkg::ST_PAD: begin
                o_cmd.push = i_st.can_push;
                o_cmd.pad  = i_st.can_push;
                o_cmd.sel  = ymf_pkg::SEL_PAD;
            end
            ymf_pkg::ST_CRCH: begin
                o_cmd.push = i_st.can_push;
                o_cmd.sel  = ymf_pkg::SEL_CRCH;
            end
            ymf_pkg::ST_CRCL: begin
                o_cmd.push  = i_st.can_push;
                o_cmd.last  = i_st.can_push;
                o_cmd.close = i_st.can_push;
                o_cmd.sel   = ymf_pkg::SEL_CRCL;
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

[rtl/core/ymf_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ymf_datapath
// File size register, packet counters, running CRC, the eight-lane byte
// packer and the result register.
// ----------------------------------------------------------------------------
module ymf_datapath #(
    parameter int LARGE_PAYLOAD = 1024,
    parameter int SMALL_PAYLOAD = 128
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [ymf_pkg::FS_W-1:0]       i_cfg_file_size,
    input  wire logic [ymf_pkg::BYTE_W-1:0]     i_data_byte,
    input  wire ymf_pkg::t_cmd                  i_cmd,
    output ymf_pkg::t_status                    o_st,
    input  wire logic                           i_out_ready,
    output logic                                o_out_valid,
    output logic [ymf_pkg::LANES_W-1:0]         o_byte_lanes,
    output logic [ymf_pkg::CNT_W-1:0]           o_byte_count,
    output logic                                o_packet_end,
    output logic                                o_file_end,
    output logic                                o_run_last
);

    localparam int POS_W = $clog2(LARGE_PAYLOAD + 1);
    localparam logic [POS_W-1:0] LARGE_M1 = POS_W'(LARGE_PAYLOAD - 1);
    localparam logic [POS_W-1:0] SMALL_M1 = POS_W'(SMALL_PAYLOAD - 1);

    logic [ymf_pkg::FS_W-1:0]    r_file_size;
    logic [ymf_pkg::FS_W-1:0]    r_rem;
    logic [POS_W-1:0]            r_pos;
    logic                        r_large;
    logic [ymf_pkg::BYTE_W-1:0]  r_block;
    logic [ymf_pkg::CRC_W-1:0]   r_crc;
    logic                        r_in_packet;
    logic [ymf_pkg::BYTE_W-1:0]  r_byte;

    logic [ymf_pkg::LANES_W-1:0] r_acc;
    logic [ymf_pkg::LCNT_W-1:0]  r_cnt;
    logic                        r_out_valid;
    logic [ymf_pkg::LANES_W-1:0] r_out_lanes;
    logic [ymf_pkg::CNT_W-1:0]   r_out_count;
    logic                        r_out_packet_end;
    logic                        r_out_file_end;
    logic                        r_out_run_last;

    logic [ymf_pkg::FS_W-1:0]    rem_eff;
    logic                        large_eff;
    logic [POS_W-1:0]            psize_m1;
    logic                        can_push;
    logic [ymf_pkg::BYTE_W-1:0]  line_byte;
    logic [ymf_pkg::LANES_W-1:0] word;
    logic                        emit;

    // zero remaining between files means reload; a zero size counts as one byte
    always_comb begin
        if (r_rem != '0) begin
            rem_eff = r_rem;
        end else if (r_file_size == '0) begin
            rem_eff = ymf_pkg::FS_W'(1);
        end else begin
            rem_eff = r_file_size;
        end
    end

    assign large_eff = rem_eff >= ymf_pkg::FS_W'(LARGE_PAYLOAD);
    assign psize_m1  = r_large ? LARGE_M1 : SMALL_M1;
    assign can_push  = !r_out_valid || i_out_ready;

    assign o_st.in_packet = r_in_packet;
    assign o_st.last_data = r_rem == ymf_pkg::FS_W'(1);
    assign o_st.pos_last  = r_pos == psize_m1;
    assign o_st.can_push  = can_push;

    always_comb begin
        case (i_cmd.sel)
            ymf_pkg::SEL_HDR:  line_byte = large_eff ? ymf_pkg::HDR_LARGE : ymf_pkg::HDR_SMALL;
            ymf_pkg::SEL_BLK:  line_byte = r_block;
            ymf_pkg::SEL_NBLK: line_byte = ~r_block;
            ymf_pkg::SEL_DIN:  line_byte = i_data_byte;
            ymf_pkg::SEL_DREG: line_byte = r_byte;
            ymf_pkg::SEL_PAD:  line_byte = ymf_pkg::PAD_BYTE;
            ymf_pkg::SEL_CRCH: line_byte = r_crc[15:8];
            ymf_pkg::SEL_CRCL: line_byte = r_crc[7:0];
            default:           line_byte = ymf_pkg::PAD_BYTE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_file_size <= ymf_pkg::FS_W'(1);
            r_rem       <= '0;
            r_pos       <= '0;
            r_large     <= 1'b0;
            r_block     <= ymf_pkg::BYTE_W'(1);
            r_crc       <= '0;
            r_in_packet <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_file_size <= i_cfg_file_size;
            end
            if (i_cmd.start) begin
                r_rem       <= rem_eff;
                r_large     <= large_eff;
                r_pos       <= '0;
                r_crc       <= '0;
                r_in_packet <= 1'b1;
            end
            if (i_cmd.data || i_cmd.pad) begin
                r_crc <= ymf_pkg::crc_byte(r_crc, line_byte);
                r_pos <= r_pos + POS_W'(1);
            end
            if (i_cmd.data) begin
                r_rem <= r_rem - ymf_pkg::FS_W'(1);
            end
            if (i_cmd.close) begin
                r_in_packet <= 1'b0;
                r_pos       <= '0;
                r_block     <= (r_rem == '0) ? ymf_pkg::BYTE_W'(1)
                                             : r_block + ymf_pkg::BYTE_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_byte <= i_data_byte;
        end
    end

    // packer: a result leaves when eight lanes are full or the input's bytes end
    always_comb begin
        word = r_acc;
        word[{r_cnt, 3'b000} +: ymf_pkg::BYTE_W] = line_byte;
    end

    assign emit = i_cmd.push && ((r_cnt == '1) || i_cmd.last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_acc       <= '0;
                r_cnt       <= '0;
                r_out_valid <= 1'b1;
            end else begin
                if (i_cmd.push) begin
                    r_acc <= word;
                    r_cnt <= r_cnt + ymf_pkg::LCNT_W'(1);
                end
                if (i_out_ready) begin
                    r_out_valid <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_lanes      <= word;
            r_out_count      <= {1'b0, r_cnt} + ymf_pkg::CNT_W'(1);
            r_out_packet_end <= i_cmd.close;
            r_out_file_end   <= i_cmd.close && (r_rem == '0);
            r_out_run_last   <= i_cmd.last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_byte_lanes = r_out_lanes;
    assign o_byte_count = r_out_count;
    assign o_packet_end = r_out_packet_end;
    assign o_file_end   = r_out_file_end;
    assign o_run_last   = r_out_run_last;

`ifndef ASSERT_OFF
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |-> can_push)
        else $error("line byte pushed while result register blocked");
    a_file_end_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_file_end |-> r_out_packet_end && r_out_run_last)
        else $error("file end without packet end on last beat");
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= psize_m1 + POS_W'(1))
        else $error("payload position beyond packet size");
    a_closed_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_packet |-> r_pos == '0)
        else $error("payload position held outside a packet");
    a_start_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.start |-> !r_in_packet && !i_cmd.data && !i_cmd.pad)
        else $error("packet opened while one is open");
`endif

endmodule
`default_nettype wire
